### sv/bclpd_pkg.sv
// Shared types and constants for the button click / long-press detector.
// No dependencies; imported by every module of the block.
package bclpd_pkg;

    localparam int unsigned IN_W  = 40;
    localparam int unsigned OUT_W = 24;

    typedef enum logic [1:0] {
        REG_SETTLE_TIME     = 2'd0,
        REG_LONG_THRESHOLD  = 2'd1,
        REG_REPEAT_INTERVAL = 2'd2,
        REG_CLICK_GAP       = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_PRESSED  = 3'd1,
        EV_RELEASED = 3'd2,
        EV_LONG     = 3'd3,
        EV_CLICKS   = 3'd4
    } event_t;

    localparam logic [15:0] SETTLE_RESET = 16'd10;
    localparam logic [15:0] LONG_RESET   = 16'd1000;
    localparam logic [15:0] REPEAT_RESET = 16'd100;
    localparam logic [15:0] GAP_RESET    = 16'd200;
    localparam logic [15:0] TICK_MAX     = 16'hFFFF;
    localparam logic [7:0]  CLICK_MAX    = 8'hFF;

    typedef struct packed {
        logic [15:0] settle_time;
        logic [15:0] long_threshold;
        logic [15:0] repeat_interval;
        logic [15:0] click_gap;
    } cfg_t;

    typedef struct packed {
        logic        debounced_level;
        logic        change_pending;
        logic [31:0] pending_since;
        logic [31:0] pressed_at;
        logic [31:0] released_at;
        logic [15:0] long_tick_count;
        logic [31:0] last_tick_at;
        logic [7:0]  click_count;
    } state_t;

    typedef struct packed {
        logic        stable_level;
        logic [15:0] event_count;
        event_t      event_code;
    } result_t;

endpackage

### sv/bclpd_cfg.sv
// Configuration register bank for the button detector.
// Depends on bclpd_pkg.
module bclpd_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  bclpd_pkg::cfg_idx_t cfg_index,
    input  logic [15:0]         cfg_data,
    output bclpd_pkg::cfg_t     cfg
);
    import bclpd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SETTLE_TIME:     cfg_next.settle_time     = cfg_data;
                REG_LONG_THRESHOLD:  cfg_next.long_threshold  = cfg_data;
                REG_REPEAT_INTERVAL: cfg_next.repeat_interval = cfg_data;
                REG_CLICK_GAP:       cfg_next.click_gap       = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_time     <= SETTLE_RESET;
            cfg_reg.long_threshold  <= LONG_RESET;
            cfg_reg.repeat_interval <= REPEAT_RESET;
            cfg_reg.click_gap       <= GAP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/bclpd_step.sv
// Per-poll update: debounce, click counting, long-press ticks, click report.
// Depends on bclpd_pkg; purely combinational between the top-level registers.
module bclpd_step (
    input  bclpd_pkg::state_t  st,
    input  bclpd_pkg::cfg_t    cfg,
    input  logic               pin_level,
    input  logic [31:0]        now_ms,
    output bclpd_pkg::state_t  st_next,
    output bclpd_pkg::result_t res
);
    import bclpd_pkg::*;

    logic [31:0] pend_age;
    logic [31:0] rel_hold;
    logic [31:0] long_hold;
    logic [31:0] tick_age;
    logic [31:0] quiet_time;

    always_comb
    begin
        st_next          = st;
        res.event_code   = EV_NONE;
        res.event_count  = '0;
        pend_age         = now_ms - st.pending_since;
        rel_hold         = now_ms - st.pressed_at;
        tick_age         = now_ms - st.last_tick_at;

        // resolve or open a pending level change
        if (st.change_pending)
        begin
            if (pend_age >= {16'd0, cfg.settle_time})
            begin
                if (pin_level != st.debounced_level)
                begin
                    if (pin_level)
                    begin
                        st_next.pressed_at = now_ms;
                        res.event_code     = EV_PRESSED;
                    end
                    else
                    begin
                        st_next.released_at     = now_ms;
                        res.event_code          = EV_RELEASED;
                        st_next.long_tick_count = '0;
                        if (rel_hold < {16'd0, cfg.long_threshold})
                        begin
                            if (st.click_count != CLICK_MAX)
                                st_next.click_count = st.click_count + 8'd1;
                        end
                        else
                        begin
                            st_next.click_count = '0;
                        end
                    end
                end
                st_next.debounced_level = pin_level;
                st_next.change_pending  = 1'b0;
            end
        end
        else if (pin_level != st.debounced_level)
        begin
            st_next.change_pending = 1'b1;
            st_next.pending_since  = now_ms;
        end

        long_hold  = now_ms - st_next.pressed_at;
        quiet_time = now_ms - st_next.released_at;

        // long-press ticks while held
        if (st_next.debounced_level)
        begin
            if (st_next.long_tick_count == '0)
            begin
                if (st_next.pressed_at != '0 && long_hold > {16'd0, cfg.long_threshold})
                begin
                    st_next.long_tick_count = 16'd1;
                    st_next.last_tick_at    = now_ms;
                    res.event_code          = EV_LONG;
                    res.event_count         = 16'd1;
                end
            end
            else if (tick_age > {16'd0, cfg.repeat_interval})
            begin
                st_next.last_tick_at = now_ms;
                if (st_next.long_tick_count != TICK_MAX)
                    st_next.long_tick_count = st_next.long_tick_count + 16'd1;
                res.event_code  = EV_LONG;
                res.event_count = st_next.long_tick_count;
            end
        end

        // report clicks after a quiet gap
        if (st_next.click_count != '0 && !st_next.debounced_level
            && quiet_time > {16'd0, cfg.click_gap})
        begin
            res.event_code      = EV_CLICKS;
            res.event_count     = {8'd0, st_next.click_count};
            st_next.click_count = '0;
        end

        res.stable_level = st_next.debounced_level;
    end

endmodule

### sv/button_click_long_press_detector.sv
// Top level of the button debouncer with multi-click and long-press detection.
// Depends on bclpd_pkg, bclpd_cfg and bclpd_step.
//
//  channel  | direction | payload (lowest bit first)
//  ---------+-----------+------------------------------------------------
//  s_*      | in        | pin_level[0], now_ms[32:1], zero pad to 40 bits
//  m_*      | out       | event_code[2:0], event_count[18:3], stable_level[19]
//  cfg_*    | in        | cfg_index selects register, cfg_data 16 bits
//
// One item per cycle sustained while m_tready is high; an accepted item passes
// through the input register, then the result register, before it is on
// m_tdata. The poll update runs in the cycle the item moves from the
// input register into the result register. A stall on m_tready holds both
// registers and drops s_tready once both are full. Reset clears the debounce
// state and restores register defaults.
module button_click_long_press_detector (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bclpd_pkg::IN_W-1:0]    s_tdata,   // pin_level, now_ms
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bclpd_pkg::OUT_W-1:0]   m_tdata,   // event_code, event_count, stable_level
    input  logic                          cfg_we,
    input  bclpd_pkg::cfg_idx_t           cfg_index,
    input  logic [15:0]                   cfg_data
);
    import bclpd_pkg::*;

    cfg_t        cfg;
    state_t      st_reg;
    state_t      st_next;
    result_t     res;
    result_t     out_res_reg;
    logic        in_valid_reg;
    logic        in_valid_next;
    logic        in_level_reg;
    logic [31:0] in_now_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        advance;
    logic        take;

    bclpd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bclpd_step u_step (
        .st        (st_reg),
        .cfg       (cfg),
        .pin_level (in_level_reg),
        .now_ms    (in_now_reg),
        .st_next   (st_next),
        .res       (res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_level_reg <= s_tdata[0];
            in_now_reg   <= s_tdata[32:1];
        end
        if (advance)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_res_reg.stable_level, out_res_reg.event_count,
                       out_res_reg.event_code};

    a_long_held : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.event_code == EV_LONG)
        |-> (out_res_reg.stable_level && out_res_reg.event_count != '0))
        else $error("long-press tick reported while released or with zero count");

    a_clicks_released : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.event_code == EV_CLICKS)
        |-> (!out_res_reg.stable_level && out_res_reg.event_count != '0
             && out_res_reg.event_count[15:8] == '0))
        else $error("click report while held or with bad count");

    a_plain_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_res_reg.event_code == EV_NONE
                           || out_res_reg.event_code == EV_PRESSED
                           || out_res_reg.event_code == EV_RELEASED))
        |-> out_res_reg.event_count == '0)
        else $error("nonzero count on an event without a count");

    a_state_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(st_reg))
        else $error("debounce state changed without an item");

endmodule

### bench/tb_top.sv
// Self-checking bench for button_click_long_press_detector: polls stream in,
// events are predicted per poll and compared with the m_* stream field by field.
// Depends on bclpd_pkg and the block's RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bclpd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;          // pin_level, now_ms, zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;               // event_code, event_count, stable_level, zero pad
    logic        cfg_we = 1'b0;
    cfg_idx_t    cfg_index = REG_SETTLE_TIME;
    logic [15:0] cfg_data = '0;

    // timing registers as the block should hold them
    logic [15:0] settle_ms = SETTLE_RESET;
    logic [15:0] long_ms   = LONG_RESET;
    logic [15:0] repeat_ms = REPEAT_RESET;
    logic [15:0] gap_ms    = GAP_RESET;

    // debounce and gesture state
    logic        btn_level    = 1'b0;
    logic        change_open  = 1'b0;
    logic [31:0] change_since = '0;
    logic [31:0] press_time   = '0;
    logic [31:0] release_time = '0;
    logic [15:0] tick_count   = '0;
    logic [31:0] tick_time    = '0;
    logic [7:0]  clicks       = '0;

    logic [39:0] poll_queue[$];
    result_t     awaited_events[$];
    logic [31:0] now_ms = '0;
    int unsigned polls_issued = 0;
    int unsigned polls_accepted = 0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic        poll_taken = 1'b0;

    button_click_long_press_detector u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    task automatic debounce_poll(input logic lvl, input logic [31:0] now, output result_t r);
        r.event_code   = EV_NONE;
        r.event_count  = '0;
        if (change_open)
        begin
            if (32'(now - change_since) >= {16'd0, settle_ms})
            begin
                if (lvl != btn_level)
                begin
                    if (lvl)
                    begin
                        press_time   = now;
                        r.event_code = EV_PRESSED;
                    end
                    else
                    begin
                        release_time = now;
                        r.event_code = EV_RELEASED;
                        tick_count   = '0;
                        if (32'(now - press_time) < {16'd0, long_ms})
                        begin
                            if (clicks != CLICK_MAX)
                                clicks = clicks + 8'd1;
                        end
                        else
                            clicks = '0;
                    end
                end
                btn_level   = lvl;
                change_open = 1'b0;
            end
        end
        else if (lvl != btn_level)
        begin
            change_open  = 1'b1;
            change_since = now;
        end

        if (btn_level)
        begin
            if (tick_count == '0)
            begin
                if (press_time != '0 && 32'(now - press_time) > {16'd0, long_ms})
                begin
                    tick_count    = 16'd1;
                    tick_time     = now;
                    r.event_code  = EV_LONG;
                    r.event_count = tick_count;
                end
            end
            else if (32'(now - tick_time) > {16'd0, repeat_ms})
            begin
                tick_time = now;
                if (tick_count != TICK_MAX)
                    tick_count = tick_count + 16'd1;
                r.event_code  = EV_LONG;
                r.event_count = tick_count;
            end
        end

        if (clicks != '0 && !btn_level && 32'(now - release_time) > {16'd0, gap_ms})
        begin
            r.event_code  = EV_CLICKS;
            r.event_count = {8'd0, clicks};
            clicks        = '0;
        end
        r.stable_level = btn_level;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch: %s got %0d want %0d (poll %0d)", what, got, want,
                 polls_accepted);
        mismatches++;
    endtask

    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || poll_taken))
        begin
            if (poll_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= poll_queue.pop_front();
            end
            else
                s_tvalid <= 1'b0;
        end
        m_tready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : watch
        result_t want;
        result_t fresh;
        poll_taken <= s_tvalid && s_tready;
        if (m_tvalid && m_tready)
        begin
            if (awaited_events.size() == 0)
                report_mismatch("unexpected result", 32'(m_tdata), 32'd0);
            else
            begin
                want = awaited_events.pop_front();
                if (m_tdata[2:0] != want.event_code)
                    report_mismatch("event_code", 32'(m_tdata[2:0]),
                                    32'(want.event_code));
                if (m_tdata[18:3] != want.event_count)
                    report_mismatch("event_count", 32'(m_tdata[18:3]),
                                    32'(want.event_count));
                if (m_tdata[19] != want.stable_level)
                    report_mismatch("stable_level", 32'(m_tdata[19]),
                                    32'(want.stable_level));
            end
        end
        if (s_tvalid && s_tready)
        begin
            debounce_poll(s_tdata[0], s_tdata[32:1], fresh);
            awaited_events.push_back(fresh);
            polls_accepted++;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic poll_at(input logic lvl, input logic [31:0] t);
        now_ms = t;
        poll_queue.push_back({7'd0, t, lvl});
        polls_issued++;
    endtask

    task automatic emit(input logic lvl, input int unsigned dt);
        poll_at(lvl, now_ms + dt);
    endtask

    task automatic hold(input logic lvl, input int unsigned dur);
        int unsigned elapsed;
        int unsigned d;
        elapsed = 0;
        while (elapsed <= dur)
        begin
            d = $urandom_range(1, dur / 3 + 1);
            emit(lvl, d);
            elapsed += d;
        end
    endtask

    task automatic bounce(input logic lvl);
        repeat ($urandom_range(0, 3))
            emit(1'($urandom_range(0, 1)), $urandom_range(0, settle_ms / 2 + 1));
        emit(lvl, $urandom_range(0, 3));
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        unique case (idx)
            REG_SETTLE_TIME:     settle_ms = val;
            REG_LONG_THRESHOLD:  long_ms   = val;
            REG_REPEAT_INTERVAL: repeat_ms = val;
            REG_CLICK_GAP:       gap_ms    = val;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_timing(input logic [15:0] st, input logic [15:0] lt,
                              input logic [15:0] rp, input logic [15:0] gp);
        write_reg(REG_SETTLE_TIME, st);
        write_reg(REG_LONG_THRESHOLD, lt);
        write_reg(REG_REPEAT_INTERVAL, rp);
        write_reg(REG_CLICK_GAP, gp);
        @(posedge clk);
    endtask

    // hold off new polls until every awaited event is back, then settle
    task automatic drain;
        while (polls_accepted != polls_issued || awaited_events.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_random(input int unsigned n);
        int unsigned target;
        int unsigned kind;
        target = polls_issued + n;
        while (polls_issued < target)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 4)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    bounce(1'b1);
                    hold(1'b1, settle_ms + $urandom_range(0, long_ms));
                    bounce(1'b0);
                    hold(1'b0, settle_ms + $urandom_range(0, gap_ms));
                end
                hold(1'b0, gap_ms + 1 + $urandom_range(0, gap_ms));
            end
            else if (kind <= 7)
            begin
                bounce(1'b1);
                hold(1'b1, settle_ms + long_ms + $urandom_range(0, 6 * repeat_ms));
                bounce(1'b0);
                hold(1'b0, settle_ms + gap_ms + 1);
            end
            else if (kind == 8)
            begin
                repeat ($urandom_range(1, 6))
                    emit(1'($urandom_range(0, 1)), $urandom_range(0, 2 * settle_ms + 2));
            end
            else
                emit(1'($urandom_range(0, 1)), $urandom());
        end
    endtask

    initial
    begin
        send_idle_pct = 6;
        recv_idle_pct = 65;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset timing: wrap of the settle window, press at time zero,
        // bounce dropped, long ticks, one click reported, late extremes
        poll_at(1'b0, 32'd0);
        poll_at(1'b1, 32'hFFFF_FFF6);
        poll_at(1'b0, 32'hFFFF_FFFA);
        poll_at(1'b1, 32'd0);
        poll_at(1'b1, 32'd2000);
        poll_at(1'b0, 32'd2001);
        poll_at(1'b0, 32'd2011);
        poll_at(1'b1, 32'd3000);
        poll_at(1'b0, 32'd3010);
        poll_at(1'b1, 32'd3020);
        poll_at(1'b1, 32'd3030);
        poll_at(1'b1, 32'd4031);
        poll_at(1'b1, 32'd4131);
        poll_at(1'b1, 32'd4132);
        poll_at(1'b0, 32'd4140);
        poll_at(1'b0, 32'd4150);
        poll_at(1'b1, 32'd4200);
        poll_at(1'b1, 32'd4210);
        poll_at(1'b0, 32'd4300);
        poll_at(1'b0, 32'd4310);
        poll_at(1'b0, 32'd4510);
        poll_at(1'b0, 32'd4511);
        poll_at(1'b1, 32'hFFFF_FFFF);
        poll_at(1'b0, 32'hFFFF_FFFF);
        poll_at(1'b0, 32'd9);
        drain;

        set_timing(16'd5, 16'd60, 16'd15, 16'd40);
        run_random(120);
        drain;
        set_timing(16'd0, 16'd1, 16'd1, 16'd1);
        run_random(50);
        drain;

        send_idle_pct = 65;
        recv_idle_pct = 6;
        set_timing(16'($urandom_range(0, 30)), 16'($urandom_range(20, 300)),
                   16'($urandom_range(1, 60)), 16'($urandom_range(1, 150)));
        run_random(120);
        drain;
        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(50);
        drain;

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_timing(16'($urandom_range(0, 65535)), 16'($urandom_range(1, 65535)),
                   16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
        run_random(40);
        drain;

        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
